// File: rtl/sltp_pkg.sv
// ----------------------------------------------------------------------------
// sltp_pkg
// Shared types and constants of the subtitle line timestamp parser.
// ----------------------------------------------------------------------------
package sltp_pkg;

  localparam int SLTP_MAX_LINE = 4096;

  localparam int CH_W   = 8;
  localparam int OFF_W  = 12;
  localparam int TIME_W = 64;
  localparam int ACC_W  = 32;

  localparam logic [ACC_W-1:0] MAG_MAX = 32'h7FFF_FFFF;

  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int HUNDREDTHS   = 100;

  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CH_W-1:0] CH_EQUALS = 8'h3D;

  typedef enum logic [1:0] {
    FLD_HOURS,
    FLD_MINUTES,
    FLD_SECONDS,
    FLD_FRACTION
  } field_t;

  typedef enum logic [2:0] {
    CALC_NONE,
    CALC_MUL,
    CALC_ADD,
    CALC_SCALE,
    CALC_DONE
  } calc_t;

  typedef struct packed {
    logic   take_char;
    logic   add_digit;
    logic   negate;
    logic   latch_offset;
    field_t field;
    calc_t  calc;
    logic   ok;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_blank;
    logic is_sign;
    logic is_minus;
    logic is_colon;
    logic is_dot;
    logic is_sep;
    logic is_term;
    logic pos_full;
  } status_t;

endpackage

// File: rtl/sltp_in_if.sv
// ----------------------------------------------------------------------------
// sltp_in_if
// Character channel: one character or an end-of-line marker per transfer.
// ----------------------------------------------------------------------------
interface sltp_in_if
  import sltp_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

// File: rtl/sltp_out_if.sv
// ----------------------------------------------------------------------------
// sltp_out_if
// Result channel: one parse result per line.
// ----------------------------------------------------------------------------
interface sltp_out_if
  import sltp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     valid_res;
  logic signed [TIME_W-1:0] time_hundredths;
  logic [OFF_W-1:0]         payload_offset;

  modport source (output valid, output valid_res, output time_hundredths,
                  output payload_offset, input ready);
  modport sink   (input valid, input valid_res, input time_hundredths,
                  input payload_offset, output ready);
endinterface

// File: rtl/sltp_datapath.sv
// ----------------------------------------------------------------------------
// sltp_datapath
// Character classification, field accumulators, position counter and the
// multi-cycle time computation with the result register.
// ----------------------------------------------------------------------------
module sltp_datapath
  import sltp_pkg::*;
#(
  parameter int MAX_LINE = SLTP_MAX_LINE
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CH_W-1:0]          ch,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic                     valid_res,
  output logic signed [TIME_W-1:0] time_hundredths,
  output logic [OFF_W-1:0]         payload_offset
);

  localparam int POS_W   = $clog2(MAX_LINE);
  localparam int PH_W    = ACC_W + 13;
  localparam int PM_W    = ACC_W + 7;
  localparam int SUM_W   = PH_W + 1;
  localparam int SCL_W   = SUM_W + 7;
  localparam int X10_W   = ACC_W + 3;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

  logic [3:0][ACC_W-1:0]    acc;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         accepted_offset;
  logic signed [PH_W-1:0]   prod_h;
  logic signed [PM_W-1:0]   prod_m;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SCL_W-1:0]  scaled;

  logic [ACC_W-1:0]         cur;
  logic [X10_W-1:0]         acc_x10;
  logic [ACC_W-1:0]         acc_sat;
  logic [POS_W-1:0]         pos_inc;
  logic [POS_W+OFF_W-1:0]   off_ext;
  logic signed [TIME_W-1:0] time_sum;

  // character classes
  always_comb begin
    status.is_digit = ch inside {[CH_ZERO:CH_NINE]};
    status.is_blank = ch inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
    status.is_sign  = ch inside {CH_PLUS, CH_MINUS};
    status.is_minus = ch == CH_MINUS;
    status.is_colon = ch == CH_COLON;
    status.is_dot   = ch == CH_DOT;
    status.is_sep   = ch inside {CH_COLON, CH_SPACE, CH_EQUALS};
    status.is_term  = ch inside {CH_NUL, CH_LF, CH_CR};
    status.pos_full = pos >= POS_LAST;
  end

  // digit accumulate with saturation at 2^31-1
  always_comb begin
    cur     = acc[cmd.field];
    acc_x10 = (X10_W'(cur) << 3) + (X10_W'(cur) << 1) + X10_W'(ch[3:0]);
    acc_sat = (|acc_x10[X10_W-1:ACC_W-1]) ? MAG_MAX : acc_x10[ACC_W-1:0];
    pos_inc = pos + POS_W'(1);
    off_ext = {{OFF_W{1'b0}}, accepted_offset};
    time_sum = TIME_W'(scaled) + TIME_W'($signed(acc[FLD_FRACTION]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc             <= '0;
      pos             <= '0;
      accepted_offset <= '0;
    end else if (cmd.calc == CALC_DONE) begin
      acc             <= '0;
      pos             <= '0;
      accepted_offset <= '0;
    end else begin
      if (cmd.take_char) begin
        pos <= pos_inc;
      end
      if (cmd.add_digit) begin
        acc[cmd.field] <= acc_sat;
      end else if (cmd.negate) begin
        acc[cmd.field] <= ACC_W'(0) - cur;
      end
      if (cmd.latch_offset) begin
        accepted_offset <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.calc)
      CALC_MUL: begin
        prod_h <= PH_W'($signed(acc[FLD_HOURS])) * PH_W'(SEC_PER_HOUR);
        prod_m <= PM_W'($signed(acc[FLD_MINUTES])) * PM_W'(SEC_PER_MIN);
      end
      CALC_ADD: begin
        sum <= SUM_W'(prod_h) + SUM_W'(prod_m) + SUM_W'($signed(acc[FLD_SECONDS]));
      end
      CALC_SCALE: begin
        scaled <= SCL_W'(sum) * SCL_W'(HUNDREDTHS);
      end
      CALC_DONE: begin
        valid_res       <= cmd.ok;
        time_hundredths <= cmd.ok ? time_sum : '0;
        payload_offset  <= cmd.ok ? off_ext[OFF_W-1:0] : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/sltp_controller.sv
// ----------------------------------------------------------------------------
// sltp_controller
// Parse-phase state machine, handshake control and sequencing of the
// end-of-line time computation.
// ----------------------------------------------------------------------------
module sltp_controller
  import sltp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_eol,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    P_H_SKIP   = 4'd0,
    P_H_DIG    = 4'd1,
    P_M_SKIP   = 4'd2,
    P_M_DIG    = 4'd3,
    P_S_SKIP   = 4'd4,
    P_S_DIG    = 4'd5,
    P_F_SKIP   = 4'd6,
    P_F_DIG    = 4'd7,
    P_ACCEPT   = 4'd8,
    P_REJECT   = 4'd9
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   field_negative, field_negative_next;
  logic   digit_seen, digit_seen_next;
  logic   out_full, out_full_next;
  logic   accept;
  logic [3:0] ph_bits;

  assign ph_bits   = phase;
  assign in_ready  = (state == ST_IDLE) && !(in_eol && out_full);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_full;

  always_comb begin
    state_next          = state;
    phase_next          = phase;
    field_negative_next = field_negative;
    digit_seen_next     = digit_seen;
    out_full_next       = out_full && !out_ready;

    cmd.take_char    = 1'b0;
    cmd.add_digit    = 1'b0;
    cmd.negate       = 1'b0;
    cmd.latch_offset = 1'b0;
    cmd.field        = field_t'(ph_bits[2:1]);
    cmd.calc         = CALC_NONE;
    cmd.ok           = phase == P_ACCEPT;

    case (state)
      ST_IDLE: begin
        if (accept && in_eol) begin
          state_next = ST_MUL;
        end else if (accept && !status.pos_full) begin
          cmd.take_char = 1'b1;
          if (phase == P_ACCEPT || phase == P_REJECT) begin
            // line already decided, characters only counted
          end else if (status.is_term) begin
            phase_next = P_REJECT;
          end else if (!ph_bits[0]) begin
            if (status.is_blank) begin
              // skip whitespace before a field
            end else if (status.is_sign) begin
              field_negative_next = status.is_minus;
              phase_next          = phase_t'(ph_bits | 4'd1);
            end else if (status.is_digit) begin
              phase_next      = phase_t'(ph_bits | 4'd1);
              cmd.add_digit   = 1'b1;
              digit_seen_next = 1'b1;
            end else begin
              phase_next = P_REJECT;
            end
          end else if (status.is_digit) begin
            cmd.add_digit   = 1'b1;
            digit_seen_next = 1'b1;
          end else if (!digit_seen) begin
            phase_next = P_REJECT;
          end else begin
            // field ends: apply sign, then check the punctuation
            cmd.negate          = field_negative;
            field_negative_next = 1'b0;
            digit_seen_next     = 1'b0;
            if (cmd.field == FLD_HOURS || cmd.field == FLD_MINUTES) begin
              phase_next = status.is_colon ? phase_t'(ph_bits + 4'd1) : P_REJECT;
            end else if (cmd.field == FLD_SECONDS && status.is_dot) begin
              phase_next = P_F_SKIP;
            end else if (status.is_sep) begin
              phase_next       = P_ACCEPT;
              cmd.latch_offset = 1'b1;
            end else begin
              phase_next = P_REJECT;
            end
          end
        end
      end
      ST_MUL: begin
        cmd.calc   = CALC_MUL;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.calc   = CALC_ADD;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.calc   = CALC_SCALE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.calc            = CALC_DONE;
        state_next          = ST_IDLE;
        phase_next          = P_H_SKIP;
        field_negative_next = 1'b0;
        digit_seen_next     = 1'b0;
        out_full_next       = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= P_H_SKIP;
      field_negative <= 1'b0;
      digit_seen     <= 1'b0;
      out_full       <= 1'b0;
    end else begin
      state          <= state_next;
      phase          <= phase_next;
      field_negative <= field_negative_next;
      digit_seen     <= digit_seen_next;
      out_full       <= out_full_next;
    end
  end

`ifndef SYNTHESIS
  // result register is always free when a computed result is written
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !out_full)
    else $error("result register overwritten");

  // an end-of-line transfer starts the computation sequence
  a_eol_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_eol) |=> (state == ST_MUL))
    else $error("end of line did not start computation");

  // a new result leaves the line state cleared
  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> (phase == P_H_SKIP && !digit_seen && !field_negative))
    else $error("line state not cleared after result");

  // the computation runs from the multiply state through add and scale to done
  a_calc_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> ##3 (state == ST_DONE))
    else $error("computation sequence length wrong");
`endif

endmodule

// File: rtl/subtitle_line_timestamp_parser.sv
// ----------------------------------------------------------------------------
// subtitle_line_timestamp_parser
// Parses a leading H:M:S[.F] timestamp from a text line, one result per line.
// ----------------------------------------------------------------------------
// Usage:
//   din carries the characters of one line, one per transfer, then a transfer
//   with end_of_line set. dout carries one result per line: valid_res, the
//   time in hundredths (0 when not valid) and the payload offset.
//   Throughput: one character per cycle while the parser is idle. An
//   end-of-line marker occupies the block while the multiply, add and scale
//   steps form the time and the done step writes it; the result then sits
//   in the output register and dout.valid rises.
//   While a result waits, characters of the next line are still taken; the
//   next end-of-line marker is held off until the waiting result has been
//   transferred, so a stalled receiver eventually stalls din.
//   Characters past MAX_LINE-1 in one line are counted out and ignored.
//   Reset (rst, synchronous) empties the output register and returns the
//   parser to the start of the hours field with all fields zero.
// ----------------------------------------------------------------------------
module subtitle_line_timestamp_parser
  import sltp_pkg::*;
#(
  parameter int MAX_LINE = SLTP_MAX_LINE
) (
  input  logic      clk,
  input  logic      rst,
  sltp_in_if.sink   din,
  sltp_out_if.source dout
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  assign din.ready  = in_ready;
  assign dout.valid = out_valid;

  sltp_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_eol    (din.end_of_line),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sltp_datapath #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ch              (din.ch),
    .cmd             (cmd),
    .status          (status),
    .valid_res       (dout.valid_res),
    .time_hundredths (dout.time_hundredths),
    .payload_offset  (dout.payload_offset)
  );

endmodule
